// ----- rtl/bsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and codes of the bitmap section allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOMEM    = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_NOTALLOC = 2'd3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] REG_BASE     = 2'd0;
	localparam logic [1:0] REG_SHIFT    = 2'd1;
	localparam logic [1:0] REG_RESERVED = 2'd2;

	localparam int unsigned OUT_CW = 11;

	typedef struct packed {
		logic       init;
		logic       load;
		logic       prep;
		logic       ascan;
		logic       amark;
		logic       fscan;
		logic       fclr;
		logic       emit;
		logic [1:0] status;
	} cmd_t;

	typedef struct packed {
		logic init_done;
		logic is_free;
		logic alloc_fail;
		logic range_bad;
		logic sect_bad;
		logic scan_found;
		logic scan_none;
		logic free_notused;
		logic mark_last;
		logic clr_last;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/bsa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_ctrl
// Sequencer of the allocator: clearing pass, request decode, scan, update.
// ----------------------------------------------------------------------------
module bsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  bsa_pkg::sts_t sts,
	output bsa_pkg::cmd_t cmd
);

	typedef enum logic [7:0] {
		S_INIT  = 8'b00000001,
		S_IDLE  = 8'b00000010,
		S_PREP  = 8'b00000100,
		S_ASCAN = 8'b00001000,
		S_AMARK = 8'b00010000,
		S_FSCAN = 8'b00100000,
		S_FCLR  = 8'b01000000,
		S_DONE  = 8'b10000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] status_q, status_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		cmd        = '0;
		cmd.status = status_q;
		case (state_q)
			S_INIT: begin
				cmd.init = 1'b1;
				if (sts.init_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				if (sts.is_free) begin
					if (sts.range_bad) begin
						status_d = bsa_pkg::ST_RANGE;
						state_d  = S_DONE;
					end else if (sts.sect_bad) begin
						status_d = bsa_pkg::ST_NOTALLOC;
						state_d  = S_DONE;
					end else begin
						state_d = S_FSCAN;
					end
				end else if (sts.alloc_fail) begin
					status_d = bsa_pkg::ST_NOMEM;
					state_d  = S_DONE;
				end else begin
					state_d = S_ASCAN;
				end
			end
			S_ASCAN: begin
				cmd.ascan = 1'b1;
				if (sts.scan_found) begin
					state_d = S_AMARK;
				end else if (sts.scan_none) begin
					status_d = bsa_pkg::ST_NOMEM;
					state_d  = S_DONE;
				end
			end
			S_AMARK: begin
				cmd.amark = 1'b1;
				if (sts.mark_last) begin
					status_d = bsa_pkg::ST_OK;
					state_d  = S_DONE;
				end
			end
			S_FSCAN: begin
				cmd.fscan = 1'b1;
				if (sts.free_notused || (sts.scan_none && !sts.scan_found)) begin
					status_d = bsa_pkg::ST_NOTALLOC;
					state_d  = S_DONE;
				end else if (sts.scan_found) begin
					state_d = S_FCLR;
				end
			end
			S_FCLR: begin
				cmd.fclr = 1'b1;
				if (sts.clr_last) begin
					status_d = bsa_pkg::ST_OK;
					state_d  = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			status_q <= bsa_pkg::ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

endmodule

// ----- rtl/bsa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_datapath
// Section bitmaps, scan counters, address arithmetic and the result register.
// ----------------------------------------------------------------------------
module bsa_datapath #(
	parameter int unsigned NUM_SECTIONS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bsa_pkg::cmd_t cmd,
	output bsa_pkg::sts_t sts,
	input  logic [31:0]   cfg_base,
	input  logic [3:0]    cfg_shift,
	input  logic [10:0]   cfg_reserved,
	input  logic          opcode,
	input  logic [23:0]   request_bytes,
	input  logic          align_on,
	input  logic [3:0]    align_log2,
	input  logic [31:0]   free_address,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    status,
	output logic [31:0]   result_address,
	output logic [10:0]   sections_moved,
	output logic [10:0]   free_count
);

	localparam int unsigned IW = $clog2(NUM_SECTIONS);
	localparam int unsigned CW = $clog2(NUM_SECTIONS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SECTIONS - 1);
	localparam logic [CW-1:0] NUM_C = CW'(NUM_SECTIONS);

	// Bit 0 is the used flag, bit 1 the end-of-allocation flag.
	logic [1:0] mem [NUM_SECTIONS];
	logic [1:0] rdata_s1;
	logic       rd_v_s1, kpos_s1;
	logic [IW-1:0] idx_s1;
	logic       we, re;
	logic [1:0] wd;

	logic        op_q, align_on_q;
	logic [23:0] bytes_q;
	logic [3:0]  align_log2_q;
	logic [31:0] free_addr_q;

	logic [CW-1:0] alloc_q, n_q, k_q, limit_q, run_q, rem_q, cnt_q, moved_q;
	logic [IW-1:0] next_fit_q, ra_q, wa_q, first_q, last_q, sect_q;
	logic [31:0]   addr_q;

	logic [3:0]    shift_eff;
	logic [CW-1:0] res_eff, cap, free_left;
	logic [25:0]   ssize, align26, size, n_wide;
	logic [31:0]   align32, diff, sect_wide;
	logic [33:0]   hi;
	logic          manual;
	logic          used_i, found_a, found_f, notused;
	logic [CW-1:0] run_base, run_inc, cnt_inc;
	logic [IW-1:0] first_sel;

	always_comb begin
		shift_eff = cfg_shift;
		if (cfg_shift < 4'd2) shift_eff = 4'd2;
		if (cfg_shift > 4'd12) shift_eff = 4'd12;
		res_eff   = (32'(cfg_reserved) > 32'(NUM_SECTIONS)) ? NUM_C : CW'(cfg_reserved);
		cap       = NUM_C - res_eff;
		free_left = (alloc_q >= cap) ? '0 : cap - alloc_q;
		ssize     = 26'(1) << shift_eff;
		align26   = 26'(1) << align_log2_q;
		align32   = 32'(1) << align_log2_q;
		manual    = align_on_q && (align26 != ssize);
		size      = 26'(bytes_q) + (manual ? align26 : 26'd0);
		n_wide    = (size + ssize - 26'd1) >> shift_eff;
		hi        = 34'(cfg_base) + (34'(NUM_SECTIONS) << shift_eff);
		diff      = free_addr_q - cfg_base;
		sect_wide = diff >> shift_eff;

		used_i    = (CW'(idx_s1) < res_eff) || rdata_s1[0];
		run_base  = (idx_s1 == '0 && kpos_s1) ? '0 : run_q;
		run_inc   = run_base + CW'(1);
		found_a   = rd_v_s1 && !used_i && (run_inc == n_q);
		first_sel = (run_base == '0) ? idx_s1 : first_q;
		notused   = rd_v_s1 && !kpos_s1 && !rdata_s1[0];
		found_f   = rd_v_s1 && rdata_s1[1] && (kpos_s1 || rdata_s1[0]);
		cnt_inc   = cnt_q + CW'(rdata_s1[0]);
	end

	always_comb begin
		sts.init_done    = (wa_q == LAST_IDX);
		sts.is_free      = (op_q == bsa_pkg::OP_FREE);
		sts.alloc_fail   = (n_wide == '0) || (n_wide > 26'(free_left));
		sts.range_bad    = !((34'(free_addr_q) > 34'(cfg_base)) && (34'(free_addr_q) < hi));
		sts.sect_bad     = (sect_wide >= 32'(NUM_SECTIONS)) || (sect_wide < 32'(res_eff));
		sts.scan_found   = cmd.ascan ? found_a : found_f;
		sts.scan_none    = (k_q == limit_q) && !rd_v_s1;
		sts.free_notused = notused;
		sts.mark_last    = (rem_q == CW'(1));
		sts.clr_last     = (wa_q == last_q);
		sts.out_free     = !out_valid || !out_stall;
		we = cmd.init || cmd.amark || cmd.fclr;
		wd = cmd.amark ? {(rem_q == CW'(1)), 1'b1} : 2'b00;
		re = (cmd.ascan || cmd.fscan) && (k_q != limit_q);
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa_q] <= wd;
		if (re) rdata_s1 <= mem[ra_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q         <= opcode;
			bytes_q      <= request_bytes;
			align_on_q   <= align_on;
			align_log2_q <= align_log2;
			free_addr_q  <= free_address;
		end
		if (re) begin
			idx_s1  <= ra_q;
			kpos_s1 <= (k_q != '0);
		end
		if (cmd.prep) begin
			n_q     <= CW'(n_wide);
			k_q     <= '0;
			run_q   <= '0;
			cnt_q   <= '0;
			sect_q  <= IW'(sect_wide);
			limit_q <= sts.is_free ? NUM_C - CW'(sect_wide) : NUM_C;
			ra_q    <= sts.is_free ? IW'(sect_wide) : next_fit_q;
		end
		if (re) begin
			ra_q <= (ra_q == LAST_IDX) ? '0 : ra_q + IW'(1);
			k_q  <= k_q + CW'(1);
		end
		if (cmd.ascan && rd_v_s1) begin
			run_q <= used_i ? '0 : run_inc;
			if (!used_i && run_base == '0) first_q <= idx_s1;
			if (found_a) begin
				rem_q  <= n_q;
				addr_q <= cfg_base + (32'(first_sel) << shift_eff);
			end
		end
		if (cmd.amark && rem_q == CW'(1)) begin
			moved_q <= n_q;
			if (manual) addr_q <= (addr_q + align32 - 32'd1) & ~(align32 - 32'd1);
		end
		if (cmd.amark) rem_q <= rem_q - CW'(1);
		if (cmd.fscan && rd_v_s1) begin
			cnt_q <= cnt_inc;
			if (found_f) begin
				moved_q <= cnt_inc;
				last_q  <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wa_q       <= '0;
			alloc_q    <= '0;
			next_fit_q <= '0;
			rd_v_s1    <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			rd_v_s1 <= re;
			if (cmd.init) wa_q <= wa_q + IW'(1);
			if (cmd.ascan && found_a) wa_q <= first_sel;
			if (cmd.fscan && found_f && !notused) wa_q <= sect_q;
			if (cmd.amark) begin
				wa_q <= wa_q + IW'(1);
				if (rem_q == CW'(1)) begin
					alloc_q    <= alloc_q + n_q;
					next_fit_q <= (wa_q == LAST_IDX) ? '0 : wa_q + IW'(1);
				end
			end
			if (cmd.fclr) begin
				wa_q <= wa_q + IW'(1);
				if (wa_q == last_q) begin
					alloc_q    <= (moved_q > alloc_q) ? '0 : alloc_q - moved_q;
					next_fit_q <= sect_q;
				end
			end
			if (cmd.emit) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status         <= cmd.status;
			result_address <= (cmd.status == bsa_pkg::ST_OK && op_q == bsa_pkg::OP_ALLOC)
				? addr_q : 32'd0;
			sections_moved <= (cmd.status == bsa_pkg::ST_OK)
				? bsa_pkg::OUT_CW'(moved_q) : '0;
			free_count     <= bsa_pkg::OUT_CW'(free_left);
		end
	end

endmodule

// ----- rtl/bitmap_section_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_section_allocator_unit
// Next-fit section allocator over one memory block with an APB register port.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall: opcode 0 allocates request_bytes
// (optionally aligned to 2**align_log2), opcode 1 frees free_address.
// Each request gives one result on out_valid/out_stall with a status, the
// aligned address, the sections moved and the free sections left.
// The user must write base address, section shift and reserved count over
// APB only while the unit is idle; the unit itself does not enforce this.
// One request is worked on at a time. An allocate scans the sections and
// then marks the sections allocated; a free scans up to the end marker and
// then clears the sections. The scan reads one bitmap entry per cycle
// from the single read port of the bitmap memory.
// After reset a clearing pass zeroes the bitmaps and no request is taken
// meanwhile. A result waits in the output register while out_stall is
// high; the next request may be taken in the meantime.
// ----------------------------------------------------------------------------
module bitmap_section_allocator_unit #(
	parameter int unsigned NUM_SECTIONS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [23:0] request_bytes,
	input  logic        align_on,
	input  logic [3:0]  align_log2,
	input  logic [31:0] free_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] result_address,
	output logic [10:0] sections_moved,
	output logic [10:0] free_count
);

	logic [31:0]   base_q;
	logic [3:0]    shift_q;
	logic [10:0]   reserved_q;
	logic          wr_en;
	bsa_pkg::cmd_t cmd;
	bsa_pkg::sts_t sts;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= 32'd0;
			shift_q    <= 4'd4;
			reserved_q <= 11'd1;
		end else if (wr_en) begin
			case (paddr[3:2])
				bsa_pkg::REG_BASE:     base_q     <= pwdata;
				bsa_pkg::REG_SHIFT:    shift_q    <= pwdata[3:0];
				bsa_pkg::REG_RESERVED: reserved_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			bsa_pkg::REG_BASE:     prdata = base_q;
			bsa_pkg::REG_SHIFT:    prdata = 32'(shift_q);
			bsa_pkg::REG_RESERVED: prdata = 32'(reserved_q);
			default:               prdata = 32'd0;
		endcase
	end

	bsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsa_datapath #(
		.NUM_SECTIONS (NUM_SECTIONS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_base       (base_q),
		.cfg_shift      (shift_q),
		.cfg_reserved   (reserved_q),
		.opcode         (opcode),
		.request_bytes  (request_bytes),
		.align_on       (align_on),
		.align_log2     (align_log2),
		.free_address   (free_address),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.result_address (result_address),
		.sections_moved (sections_moved),
		.free_count     (free_count)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken without the unit going busy");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bsa_pkg::ST_OK |-> result_address == 32'd0 && sections_moved == 11'd0)
		else $error("error result carries an address or a section count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_address)
			&& $stable(sections_moved) && $stable(free_count))
		else $error("stalled result changed");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_valid || !out_stall)
		else $error("result written over one still waiting");

endmodule

// ----- tb/bitmap_section_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_section_allocator_unit_tb
// Self-checking bench for the next-fit bitmap section allocator.
// ----------------------------------------------------------------------------
// Allocate and free requests are sent through the valid/stall request
// channel under several register settings. A behavioral model of the
// bitmaps, the next-fit pointer and the allocated count predicts each
// result, and a scoreboard compares the results field by field in order.
// ----------------------------------------------------------------------------
module bitmap_section_allocator_unit_tb;

	localparam int NSECT = 1024;

	typedef struct packed {
		logic [1:0]  st;
		logic [31:0] addr;
		logic [10:0] moved;
		logic [10:0] left;
	} alloc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        opcode = 1'b0;
	logic [23:0] request_bytes = '0;
	logic        align_on = 1'b0;
	logic [3:0]  align_log2 = '0;
	logic [31:0] free_address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] result_address;
	logic [10:0] sections_moved;
	logic [10:0] free_count;

	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int allocs_sent = 0;
	int frees_sent = 0;
	int results_seen = 0;

	// Model state.
	logic [31:0] m_base;
	logic [3:0]  m_shift;
	logic [10:0] m_reserved;
	bit          m_used [NSECT];
	bit          m_end [NSECT];
	int unsigned m_next;
	int unsigned m_count;
	logic [31:0] live_addrs [$];

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 10000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	class result_board;
		alloc_result_t pending [$];

		function void note_request(alloc_result_t r);
			pending.push_back(r);
		endfunction

		task automatic check_result(alloc_result_t got);
			alloc_result_t want;
			if (pending.size() == 0) begin
				report("unexpected result", 32'(got.st), 32'd0);
			end else begin
				want = pending.pop_front();
				if (got.st !== want.st) report("status", 32'(got.st), 32'(want.st));
				if (got.addr !== want.addr) report("result_address", got.addr, want.addr);
				if (got.moved !== want.moved)
					report("sections_moved", 32'(got.moved), 32'(want.moved));
				if (got.left !== want.left)
					report("free_count", 32'(got.left), 32'(want.left));
			end
		endtask
	endclass

	result_board board = new();

	bitmap_section_allocator_unit #(.NUM_SECTIONS(NSECT)) i_dut (.*);

	function automatic int unsigned eff_shift();
		return m_shift < 2 ? 2 : (m_shift > 12 ? 12 : m_shift);
	endfunction

	function automatic int unsigned eff_reserved();
		return m_reserved > NSECT ? NSECT : m_reserved;
	endfunction

	function automatic logic [10:0] sections_left();
		int unsigned cap;
		cap = NSECT - eff_reserved();
		return m_count >= cap ? 11'd0 : 11'(cap - m_count);
	endfunction

	function automatic alloc_result_t make_result(logic [1:0] st, logic [31:0] a, int unsigned n);
		alloc_result_t r;
		r.st = st;
		r.addr = a;
		r.moved = 11'(n);
		r.left = sections_left();
		return r;
	endfunction

	function automatic alloc_result_t predict_alloc(logic [23:0] bytes, logic aon, logic [3:0] alog);
		int unsigned sh, ssize, size, algn, n, run, first, i;
		bit manual;
		logic [31:0] a;
		sh = eff_shift();
		ssize = 1 << sh;
		algn = 1 << alog;
		manual = aon && algn != ssize;
		size = bytes;
		if (manual) size += algn;
		n = (size + ssize - 1) >> sh;
		if (n == 0 || n > sections_left()) return make_result(bsa_pkg::ST_NOMEM, 0, 0);
		run = 0;
		first = 0;
		for (int k = 0; k < NSECT; k++) begin
			i = (m_next + k) % NSECT;
			if (i == 0 && k > 0) run = 0;
			if (i < eff_reserved() || m_used[i]) begin
				run = 0;
				continue;
			end
			if (run == 0) first = i;
			run++;
			if (run == n) begin
				a = m_base + (first << sh);
				for (int j = first; j < first + n; j++) m_used[j] = 1;
				m_end[first + n - 1] = 1;
				if (manual && (a & (algn - 1)) != 0) a += algn - (a & (algn - 1));
				m_count += n;
				m_next = (first + n) % NSECT;
				live_addrs.push_back(m_base + (first << sh) + 32'(sh > 0 ? 1 : 0));
				return make_result(bsa_pkg::ST_OK, a, n);
			end
		end
		return make_result(bsa_pkg::ST_NOMEM, 0, 0);
	endfunction

	function automatic alloc_result_t predict_free(logic [31:0] fa);
		int unsigned sh, sect, last, cleared;
		longint unsigned lo, hi;
		bit found;
		sh = eff_shift();
		lo = m_base;
		hi = lo + (longint'(NSECT) << sh);
		if (!(fa > lo && fa < hi)) return make_result(bsa_pkg::ST_RANGE, 0, 0);
		sect = (longint'(fa) - lo) >> sh;
		if (sect >= NSECT || sect < eff_reserved() || !m_used[sect])
			return make_result(bsa_pkg::ST_NOTALLOC, 0, 0);
		found = 0;
		last = 0;
		for (int i = sect; i < NSECT; i++) begin
			if (m_end[i]) begin
				last = i;
				found = 1;
				break;
			end
		end
		if (!found) return make_result(bsa_pkg::ST_NOTALLOC, 0, 0);
		m_end[last] = 0;
		cleared = 0;
		for (int i = sect; i <= last; i++) begin
			if (m_used[i]) begin
				m_used[i] = 0;
				cleared++;
			end
		end
		m_count = cleared > m_count ? 0 : m_count - cleared;
		m_next = sect;
		return make_result(bsa_pkg::ST_OK, 0, cleared);
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		paddr <= {idx, 2'b00};
		pwdata <= val;
		pwrite <= 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			bsa_pkg::REG_BASE: m_base = val;
			bsa_pkg::REG_SHIFT: m_shift = val[3:0];
			default: m_reserved = val[10:0];
		endcase
	endtask

	task automatic send_request(input logic op, input logic [23:0] bytes, input logic aon,
			input logic [3:0] alog, input logic [31:0] fa);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		request_bytes <= bytes;
		align_on <= aon;
		align_log2 <= alog;
		free_address <= fa;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (op == bsa_pkg::OP_ALLOC) begin
			board.note_request(predict_alloc(bytes, aon, alog));
			allocs_sent++;
		end else begin
			board.note_request(predict_free(fa));
			frees_sent++;
		end
	endtask

	task automatic end_stream();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		end_stream();
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (NSECT * 2 + 16) @(posedge clk);
	endtask

	task automatic random_alloc();
		logic [23:0] b;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70) b = 24'($urandom_range(1, 400));
		else if (pick < 90) b = 24'($urandom_range(1, 4096));
		else if (pick < 95) b = 24'($urandom);
		else b = 24'($urandom_range(0, 3));
		send_request(bsa_pkg::OP_ALLOC, b, 1'($urandom), 4'($urandom), 32'($urandom));
	endtask

	task automatic random_free();
		logic [31:0] fa;
		int unsigned pick, idx;
		pick = $urandom_range(99);
		if (pick < 75 && live_addrs.size() > 0) begin
			idx = $urandom_range(live_addrs.size() - 1);
			fa = live_addrs[idx];
			live_addrs.delete(idx);
		end else if (pick < 90) begin
			fa = m_base + 32'($urandom_range(0, (NSECT << eff_shift()) - 1));
		end else begin
			fa = 32'($urandom);
		end
		send_request(bsa_pkg::OP_FREE, 24'($urandom), 1'($urandom), 4'($urandom), fa);
	endtask

	task automatic random_phase(input int items);
		for (int k = 0; k < items; k++) begin
			if ($urandom_range(99) < 55) random_alloc();
			else random_free();
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			board.check_result('{status, result_address, sections_moved, free_count});
			results_seen <= results_seen + 1;
		end
		out_stall <= recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct;
	end

	initial begin
		m_base = 0;
		m_shift = 4;
		m_reserved = 1;
		m_next = 0;
		m_count = 0;
		foreach (m_used[i]) begin
			m_used[i] = 0;
			m_end[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at reset settings.
		send_request(bsa_pkg::OP_ALLOC, 24'd0, 1'b0, 4'd0, 32'd0);
		send_request(bsa_pkg::OP_ALLOC, 24'd1, 1'b0, 4'd0, 32'd0);
		send_request(bsa_pkg::OP_ALLOC, 24'd100, 1'b1, 4'd6, 32'd0);
		send_request(bsa_pkg::OP_ALLOC, 24'd16, 1'b1, 4'd4, 32'd0);
		send_request(bsa_pkg::OP_ALLOC, 24'hFFFFFF, 1'b1, 4'd15, 32'hFFFFFFFF);
		send_request(bsa_pkg::OP_FREE, 24'd0, 1'b0, 4'd0, 32'd0);
		send_request(bsa_pkg::OP_FREE, 24'd0, 1'b0, 4'd0, 32'd5);
		send_request(bsa_pkg::OP_FREE, 24'd0, 1'b0, 4'd0, 32'd16);
		send_request(bsa_pkg::OP_FREE, 24'd0, 1'b0, 4'd0, 32'h4000);
		send_request(bsa_pkg::OP_FREE, 24'd0, 1'b0, 4'd0, 32'd40);
		send_request(bsa_pkg::OP_FREE, 24'd0, 1'b0, 4'd0, 32'd40);
		send_request(bsa_pkg::OP_ALLOC, 24'd16368, 1'b0, 4'd0, 32'd0);
		send_request(bsa_pkg::OP_ALLOC, 24'd16, 1'b0, 4'd0, 32'd0);
		send_request(bsa_pkg::OP_FREE, 24'd0, 1'b0, 4'd0, 32'd20);
		send_request(bsa_pkg::OP_ALLOC, 24'd8000, 1'b0, 4'd0, 32'd0);
		send_request(bsa_pkg::OP_ALLOC, 24'd9000, 1'b0, 4'd0, 32'd0);
		wait_drained();

		// Saturated and extreme register values; reserved can exceed the block.
		write_reg(bsa_pkg::REG_BASE, 32'hFFFFF000);
		write_reg(bsa_pkg::REG_SHIFT, 32'd15);
		write_reg(bsa_pkg::REG_RESERVED, 32'h7FF);
		send_request(bsa_pkg::OP_ALLOC, 24'd4, 1'b0, 4'd0, 32'd0);
		send_request(bsa_pkg::OP_FREE, 24'd0, 1'b0, 4'd0, 32'hFFFFF004);
		wait_drained();
		write_reg(bsa_pkg::REG_SHIFT, 32'd0);
		write_reg(bsa_pkg::REG_RESERVED, 32'd0);
		send_request(bsa_pkg::OP_ALLOC, 24'd4, 1'b1, 4'd12, 32'd0);
		send_request(bsa_pkg::OP_ALLOC, 24'd4096, 1'b0, 4'd0, 32'd0);
		send_request(bsa_pkg::OP_FREE, 24'd0, 1'b0, 4'd0, 32'hFFFFF000);
		wait_drained();

		send_idle_pct = 12;
		recv_idle_pct = 47;
		write_reg(bsa_pkg::REG_BASE, 32'h00010000);
		write_reg(bsa_pkg::REG_SHIFT, 32'd2);
		write_reg(bsa_pkg::REG_RESERVED, 32'd3);
		random_phase(190);
		wait_drained();

		send_idle_pct = 47;
		recv_idle_pct = 12;
		write_reg(bsa_pkg::REG_BASE, 32'h80000000);
		write_reg(bsa_pkg::REG_SHIFT, 32'd12);
		write_reg(bsa_pkg::REG_RESERVED, 32'd1024);
		random_phase(10);
		wait_drained();
		write_reg(bsa_pkg::REG_RESERVED, 32'd700);
		random_phase(180);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(bsa_pkg::REG_BASE, 32'h12345000);
		write_reg(bsa_pkg::REG_SHIFT, 32'd6);
		write_reg(bsa_pkg::REG_RESERVED, 32'd17);
		random_phase(190);
		wait_drained();

		$display("Sent %0d allocates and %0d frees over seven register settings.",
			allocs_sent, frees_sent);
		$display("Checked %0d results with %0d mismatches.", results_seen, errors);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
